/* design/cspf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cspf_pkg: shared definitions for the call stack function profiler
// Field widths, status codes, sequencer states and the structs that pass
// between the profiler's modules.
// ----------------------------------------------------------------------------
package cspf_pkg;

   // default sizes
   localparam int unsigned NUM_FUNCS_DEF   = 256;
   localparam int unsigned STACK_DEPTH_DEF = 64;

   // field widths
   localparam int unsigned OP_W    = 2;
   localparam int unsigned FID_W   = 8;
   localparam int unsigned TIME_W  = 64;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned DEPTH_W = 6;

   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 168;

   // opcodes; any other code reads counters
   localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
   localparam logic [OP_W-1:0] OP_EXIT  = 2'd1;

   // status codes
   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_MISMATCH = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_BAD_ID   = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_E_FETCH,
      ST_E_SUB,
      ST_E_ADD,
      ST_E_COUNT,
      ST_E_WRITE,
      ST_X_SUB_S,
      ST_X_ADD_S,
      ST_X_SUB_C,
      ST_X_ADD_C,
      ST_X_WRITE,
      ST_DONE
   } state_type;

   // per-function counters, one word of the statistics table
   typedef struct packed {
      logic [COUNT_W-1:0] call_count;
      logic [TIME_W-1:0]  cum_ticks;
      logic [TIME_W-1:0]  self_ticks;
   } stats_type;

   // request to the shared adder
   typedef struct packed {
      logic              op_sub;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
   } alu_req_type;

endpackage
`default_nettype wire

/* design/call_stack_function_profiler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// call_stack_function_profiler: per-function self and cumulative time profiler
// Follows enter/exit/read events against a call stack and per-function tables.
// ----------------------------------------------------------------------------
// Sequence: a bad id goes straight to the response; read, overflow and
//   mismatch pass through the lookup state only; an enter with no caller
//   skips the caller fetch and charge; an exit charges self, then cum time.
// Flow: one transaction at a time, as req_tready is high only in idle; the
//   single shared 64-bit adder and the tables, one write and one read port
//   each, pace the steps. A stalled result holds the sequencer until taken.
// Reset: synchronous; clears the stack pointer, then sweeps every entry of the
//   statistics table to zero with req_tready low.
// ----------------------------------------------------------------------------
module call_stack_function_profiler #(
   parameter int unsigned NUM_FUNCS   = cspf_pkg::NUM_FUNCS_DEF,
   parameter int unsigned STACK_DEPTH = cspf_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // opcode[1:0], func_id[9:2], timestamp[73:10], zero pad[79:74]
   input  wire logic [cspf_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status[1:0], call_count[33:2], self_ticks[97:34], cum_ticks[161:98],
   // stack_depth[167:162]
   output logic      [cspf_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int unsigned ID_W = $clog2(NUM_FUNCS);
   localparam int unsigned SP_W = $clog2(STACK_DEPTH);
   localparam int unsigned ST_W = $bits(cspf_pkg::stats_type);

   localparam logic [16:0]     NF_LIMIT = 17'(NUM_FUNCS);
   localparam logic [ID_W-1:0] CLR_LAST = ID_W'(NUM_FUNCS - 1);
   localparam logic [SP_W-1:0] TOP_MAX  = SP_W'(STACK_DEPTH - 1);

   // ---------------------------------------------------------------------
   // Request fields
   // ---------------------------------------------------------------------
   logic [cspf_pkg::OP_W-1:0]   req_op;
   logic [cspf_pkg::FID_W-1:0]  req_id;
   logic [cspf_pkg::TIME_W-1:0] req_ts;
   logic                        req_fire;
   logic                        req_bad;

   assign req_op = req_tdata[1:0];
   assign req_id = req_tdata[9:2];
   assign req_ts = req_tdata[73:10];

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   cspf_pkg::state_type           state_ff, state_in;
   logic [ID_W-1:0]               clr_ff;
   logic [SP_W-1:0]               top_ff;
   logic                          rsp_tvalid_ff;
   logic [cspf_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;

   // event held while the sequencer works on it
   logic [cspf_pkg::OP_W-1:0]     op_ff;
   logic [cspf_pkg::FID_W-1:0]    id_ff;
   logic [cspf_pkg::TIME_W-1:0]   ts_ff;
   logic [cspf_pkg::STAT_W-1:0]   status_ff;
   cspf_pkg::stats_type           stat_ff;     // callee counters
   cspf_pkg::stats_type           cstat_ff;    // caller counters on enter
   logic [cspf_pkg::TIME_W-1:0]   resume_ff;
   logic [cspf_pkg::TIME_W-1:0]   entry_ff;
   logic [cspf_pkg::FID_W-1:0]    caller_ff;
   logic                          charge_ff;

   // ---------------------------------------------------------------------
   // Table ports
   // ---------------------------------------------------------------------
   logic                          st_wr_en;
   logic [ID_W-1:0]               st_wr_addr;
   cspf_pkg::stats_type           st_wr_data;
   logic [ID_W-1:0]               st_rd_addr;
   logic [ST_W-1:0]               st_rd_raw;
   cspf_pkg::stats_type           st_rd;

   logic                          rs_wr_en;
   logic [ID_W-1:0]               rs_wr_addr;
   logic [ID_W-1:0]               rs_rd_addr;
   logic [cspf_pkg::TIME_W-1:0]   rs_rd_data;

   logic                          en_wr_en;
   logic [cspf_pkg::TIME_W-1:0]   en_rd_data;

   logic                          sk_wr_en;
   logic [SP_W-1:0]               sk_rd_addr;
   logic [cspf_pkg::FID_W-1:0]    sk_rd_data;

   cspf_pkg::alu_req_type         alu_req;
   logic [cspf_pkg::TIME_W-1:0]   alu_res;

   assign st_rd = cspf_pkg::stats_type'(st_rd_raw);

   // ---------------------------------------------------------------------
   // Address forms of function ids
   // ---------------------------------------------------------------------
   logic [ID_W+7:0]  req_ext, id_ext, caller_ext;
   logic [ID_W-1:0]  req_addr, id_addr, caller_addr;
   logic [SP_W-1:0]  top_inc, top_dec;
   logic [SP_W+5:0]  depth_ext;
   logic [cspf_pkg::FID_W-1:0] lk_caller, x_caller;

   assign req_ext     = {{ID_W{1'b0}}, req_id};
   assign id_ext      = {{ID_W{1'b0}}, id_ff};
   assign caller_ext  = {{ID_W{1'b0}}, caller_ff};
   assign req_addr    = req_ext[ID_W-1:0];
   assign id_addr     = id_ext[ID_W-1:0];
   assign caller_addr = caller_ext[ID_W-1:0];

   assign top_inc   = top_ff + 1'b1;
   assign top_dec   = top_ff - 1'b1;
   assign depth_ext = {6'd0, top_ff};

   // slot zero of the stack is the "no caller" mark; never stored in the RAM
   assign lk_caller = (top_ff == '0)  ? '0 : sk_rd_data;
   assign x_caller  = (top_dec == '0) ? '0 : sk_rd_data;

   assign req_bad  = (req_id == '0) || ({9'd0, req_id} >= NF_LIMIT);
   assign req_tready = (state_ff == cspf_pkg::ST_IDLE);
   assign req_fire = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // Sequencer: state register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cspf_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state, table and adder controls
   // ---------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      st_wr_en   = 1'b0;
      st_wr_addr = id_addr;
      st_wr_data = stat_ff;
      st_rd_addr = req_addr;
      rs_wr_en   = 1'b0;
      rs_wr_addr = id_addr;
      rs_rd_addr = req_addr;
      en_wr_en   = 1'b0;
      sk_wr_en   = 1'b0;
      sk_rd_addr = top_ff;
      alu_req    = '0;

      unique case (state_ff)
         cspf_pkg::ST_CLEAR: begin
            // sweep the statistics table to zero
            st_wr_en   = 1'b1;
            st_wr_addr = clr_ff;
            st_wr_data = '0;
            if (clr_ff == CLR_LAST) begin
               state_in = cspf_pkg::ST_IDLE;
            end
         end
         cspf_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = req_bad ? cspf_pkg::ST_DONE : cspf_pkg::ST_LOOKUP;
            end
         end
         cspf_pkg::ST_LOOKUP: begin
            if (op_ff == cspf_pkg::OP_ENTER) begin
               if (top_ff == TOP_MAX) begin
                  state_in = cspf_pkg::ST_DONE;
               end else begin
                  // push the callee
                  sk_wr_en = 1'b1;
                  state_in = (lk_caller == '0) ? cspf_pkg::ST_E_COUNT
                                               : cspf_pkg::ST_E_FETCH;
               end
            end else if (op_ff == cspf_pkg::OP_EXIT) begin
               if (top_ff == '0 || sk_rd_data != id_ff) begin
                  state_in = cspf_pkg::ST_DONE;
               end else begin
                  state_in = cspf_pkg::ST_X_SUB_S;
               end
            end else begin
               state_in = cspf_pkg::ST_DONE;
            end
         end
         cspf_pkg::ST_E_FETCH: begin
            st_rd_addr = caller_addr;
            rs_rd_addr = caller_addr;
            state_in   = cspf_pkg::ST_E_SUB;
         end
         cspf_pkg::ST_E_SUB: begin
            // caller slice = now - resume
            alu_req.op_sub = 1'b1;
            alu_req.a      = ts_ff;
            alu_req.b      = rs_rd_data;
            state_in       = cspf_pkg::ST_E_ADD;
         end
         cspf_pkg::ST_E_ADD: begin
            alu_req.a = cstat_ff.self_ticks;
            alu_req.b = alu_res;
            state_in  = cspf_pkg::ST_E_COUNT;
         end
         cspf_pkg::ST_E_COUNT: begin
            if (charge_ff) begin
               st_wr_en   = 1'b1;
               st_wr_addr = caller_addr;
               st_wr_data = '{call_count: cstat_ff.call_count,
                              cum_ticks:  cstat_ff.cum_ticks,
                              self_ticks: alu_res};
            end
            alu_req.a = {32'd0, stat_ff.call_count};
            alu_req.b = 64'd1;
            state_in  = cspf_pkg::ST_E_WRITE;
         end
         cspf_pkg::ST_E_WRITE: begin
            st_wr_en   = 1'b1;
            st_wr_data = '{call_count: alu_res[cspf_pkg::COUNT_W-1:0],
                           cum_ticks:  stat_ff.cum_ticks,
                           self_ticks: stat_ff.self_ticks};
            rs_wr_en   = 1'b1;
            en_wr_en   = 1'b1;
            state_in   = cspf_pkg::ST_DONE;
         end
         cspf_pkg::ST_X_SUB_S: begin
            alu_req.op_sub = 1'b1;
            alu_req.a      = ts_ff;
            alu_req.b      = resume_ff;
            sk_rd_addr     = top_dec;
            state_in       = cspf_pkg::ST_X_ADD_S;
         end
         cspf_pkg::ST_X_ADD_S: begin
            alu_req.a = stat_ff.self_ticks;
            alu_req.b = alu_res;
            state_in  = cspf_pkg::ST_X_SUB_C;
         end
         cspf_pkg::ST_X_SUB_C: begin
            alu_req.op_sub = 1'b1;
            alu_req.a      = ts_ff;
            alu_req.b      = entry_ff;
            state_in       = cspf_pkg::ST_X_ADD_C;
         end
         cspf_pkg::ST_X_ADD_C: begin
            alu_req.a = stat_ff.cum_ticks;
            alu_req.b = alu_res;
            state_in  = cspf_pkg::ST_X_WRITE;
         end
         cspf_pkg::ST_X_WRITE: begin
            st_wr_en   = 1'b1;
            st_wr_data = '{call_count: stat_ff.call_count,
                           cum_ticks:  alu_res,
                           self_ticks: stat_ff.self_ticks};
            // restart the caller's clock
            if (caller_ff != '0) begin
               rs_wr_en   = 1'b1;
               rs_wr_addr = caller_addr;
            end
            state_in = cspf_pkg::ST_DONE;
         end
         cspf_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = cspf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cspf_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control registers: stack pointer, clear sweep, response valid
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff        <= '0;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (state_ff == cspf_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == cspf_pkg::ST_LOOKUP && op_ff == cspf_pkg::OP_ENTER &&
             top_ff != TOP_MAX) begin
            top_ff <= top_inc;
         end
         if (state_ff == cspf_pkg::ST_X_WRITE) begin
            top_ff <= top_dec;
         end
         if (state_ff == cspf_pkg::ST_DONE && (!rsp_tvalid_ff || rsp_tready)) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Event payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      case (state_ff)
         cspf_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_ff <= req_op;
               id_ff <= req_id;
               ts_ff <= req_ts;
               if (req_bad) begin
                  status_ff <= cspf_pkg::STATUS_BAD_ID;
                  stat_ff   <= '0;
               end else begin
                  status_ff <= cspf_pkg::STATUS_OK;
               end
            end
         end
         cspf_pkg::ST_LOOKUP: begin
            stat_ff   <= st_rd;
            resume_ff <= rs_rd_data;
            entry_ff  <= en_rd_data;
            caller_ff <= lk_caller;
            charge_ff <= (lk_caller != '0);
            if (op_ff == cspf_pkg::OP_ENTER && top_ff == TOP_MAX) begin
               status_ff <= cspf_pkg::STATUS_OVERFLOW;
            end
            if (op_ff == cspf_pkg::OP_EXIT && (top_ff == '0 || sk_rd_data != id_ff)) begin
               status_ff <= cspf_pkg::STATUS_MISMATCH;
            end
         end
         cspf_pkg::ST_E_SUB: begin
            cstat_ff <= st_rd;
         end
         cspf_pkg::ST_E_COUNT: begin
            // recursion: the caller is the callee, keep its fresh self time
            if (charge_ff && caller_ff == id_ff) begin
               stat_ff.self_ticks <= alu_res;
            end
         end
         cspf_pkg::ST_E_WRITE: begin
            stat_ff.call_count <= alu_res[cspf_pkg::COUNT_W-1:0];
         end
         cspf_pkg::ST_X_ADD_S: begin
            caller_ff <= x_caller;
         end
         cspf_pkg::ST_X_SUB_C: begin
            stat_ff.self_ticks <= alu_res;
         end
         cspf_pkg::ST_X_WRITE: begin
            stat_ff.cum_ticks <= alu_res;
         end
         default: begin
         end
      endcase

      if (state_ff == cspf_pkg::ST_DONE && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tdata_ff <= {depth_ext[5:0], stat_ff.cum_ticks, stat_ff.self_ticks,
                          stat_ff.call_count, status_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------------
   // Tables and the shared adder
   // ---------------------------------------------------------------------
   cspf_ram #(
      .WIDTH (ST_W),
      .DEPTH (NUM_FUNCS)
   ) u_stats_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_raw)
   );

   cspf_ram #(
      .WIDTH (cspf_pkg::TIME_W),
      .DEPTH (NUM_FUNCS)
   ) u_resume_ram (
      .clock   (clock),
      .wr_en   (rs_wr_en),
      .wr_addr (rs_wr_addr),
      .wr_data (ts_ff),
      .rd_addr (rs_rd_addr),
      .rd_data (rs_rd_data)
   );

   cspf_ram #(
      .WIDTH (cspf_pkg::TIME_W),
      .DEPTH (NUM_FUNCS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (en_wr_en),
      .wr_addr (id_addr),
      .wr_data (ts_ff),
      .rd_addr (req_addr),
      .rd_data (en_rd_data)
   );

   cspf_ram #(
      .WIDTH (cspf_pkg::FID_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (sk_wr_en),
      .wr_addr (top_inc),
      .wr_data (id_ff),
      .rd_addr (sk_rd_addr),
      .rd_data (sk_rd_data)
   );

   cspf_alu u_alu (
      .clock  (clock),
      .req    (alu_req),
      .result (alu_res)
   );

endmodule
`default_nettype wire

/* design/cspf_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cspf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cspf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/cspf_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cspf_alu: shared 64-bit add/subtract unit
// Registered result, available the cycle after the request.
// ----------------------------------------------------------------------------
module cspf_alu (
   input  wire logic                        clock,
   input  wire cspf_pkg::alu_req_type       req,
   output logic [cspf_pkg::TIME_W-1:0]      result
);

   logic [cspf_pkg::TIME_W-1:0] result_ff;

   always_ff @(posedge clock) begin
      if (req.op_sub) begin
         result_ff <= req.a - req.b;
      end else begin
         result_ff <= req.a + req.b;
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire
